/* sv/qdwc_pkg.sv */
`default_nettype none
package qdwc_pkg;

  localparam int unsigned LANES     = 8;
  localparam int unsigned OUT_LANES = 8;
  localparam int unsigned LANE_LIMIT = (LANES < OUT_LANES) ? LANES : OUT_LANES;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ACC_W  = 32;
  localparam int unsigned CNT_W  = 4;
  localparam int unsigned DIFF_W = BYTE_W + 1;
  localparam int unsigned PROD_W = 2 * DIFF_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = BYTE_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_ZP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ZP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_SG = 2'd2;

  typedef logic [ACC_W-1:0] acc_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // shared by every lane
  typedef struct packed {
    logic load;    // capture a new tap into the product register
    logic retire;  // fold the held product into the accumulator
    logic clear;   // held tap is the last one: restart the accumulator
  } lane_ctrl_t;

  // byte as -128..255, sign-extended when sgn is set
  function automatic logic signed [DIFF_W-1:0] byte_ext(input logic [BYTE_W-1:0] b,
                                                        input logic sgn);
    byte_ext = sgn ? $signed({b[BYTE_W-1], b}) : $signed({1'b0, b});
  endfunction

endpackage
`default_nettype wire

/* sv/qdwc_ifs.sv */
`default_nettype none
interface qdwc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] input_bytes;
  logic [63:0] filter_bytes;
  logic [3:0]  active_lanes;
  logic        last_tap;

  modport source (output valid, input_bytes, filter_bytes, active_lanes, last_tap,
                  input ready);
  modport sink   (input valid, input_bytes, filter_bytes, active_lanes, last_tap,
                  output ready);
endinterface

interface qdwc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sum_lane0;
  logic signed [31:0] sum_lane1;
  logic signed [31:0] sum_lane2;
  logic signed [31:0] sum_lane3;
  logic signed [31:0] sum_lane4;
  logic signed [31:0] sum_lane5;
  logic signed [31:0] sum_lane6;
  logic signed [31:0] sum_lane7;
  logic [3:0]         valid_lanes;

  modport source (output valid, sum_lane0, sum_lane1, sum_lane2, sum_lane3, sum_lane4,
                  sum_lane5, sum_lane6, sum_lane7, valid_lanes, input ready);
  modport sink   (input valid, sum_lane0, sum_lane1, sum_lane2, sum_lane3, sum_lane4,
                  sum_lane5, sum_lane6, sum_lane7, valid_lanes, output ready);
endinterface
`default_nettype wire

/* sv/qdwc_lane.sv */
`default_nettype none
module qdwc_lane import qdwc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lane_ctrl_t        ctrl_i,
  input  wire logic              en_i,
  input  wire logic [BYTE_W-1:0] in_byte_i,
  input  wire logic [BYTE_W-1:0] filt_byte_i,
  input  wire logic [BYTE_W-1:0] izp_i,
  input  wire logic [BYTE_W-1:0] fzp_i,
  input  wire logic              fsgn_i,
  output acc_t                   sum_o
);

  logic signed [DIFF_W-1:0] x_d, w_d;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic                     en_q;
  acc_t                     acc_q, acc_d, prod_ext;

  // both differences stay within -255..255
  assign x_d    = $signed({1'b0, in_byte_i}) - $signed({1'b0, izp_i});
  assign w_d    = byte_ext(filt_byte_i, fsgn_i) - byte_ext(fzp_i, fsgn_i);
  assign prod_d = x_d * w_d;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
    end else if (ctrl_i.load) begin
      en_q <= en_i;
    end
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  // inactive lane contributes nothing and reads as zero in a result
  assign sum_o    = en_q ? acc_q + prod_ext : '0;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.retire) begin
      if (ctrl_i.clear) begin
        acc_d = '0;
      end else if (en_q) begin
        acc_d = sum_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule
`default_nettype wire

/* sv/qdwc_merge.sv */
`default_nettype none
module qdwc_merge import qdwc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  load_i,
  input  wire acc_t  sums_i [OUT_LANES],
  input  wire cnt_t  cnt_i,
  output logic       free_o,
  qdwc_out_if.source out_o
);

  acc_t sums_q [OUT_LANES];
  cnt_t cnt_q;
  logic valid_q;

  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sums_q <= sums_i;
      cnt_q  <= cnt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.sum_lane0   = $signed(sums_q[0]);
  assign out_o.sum_lane1   = $signed(sums_q[1]);
  assign out_o.sum_lane2   = $signed(sums_q[2]);
  assign out_o.sum_lane3   = $signed(sums_q[3]);
  assign out_o.sum_lane4   = $signed(sums_q[4]);
  assign out_o.sum_lane5   = $signed(sums_q[5]);
  assign out_o.sum_lane6   = $signed(sums_q[6]);
  assign out_o.sum_lane7   = $signed(sums_q[7]);
  assign out_o.valid_lanes = cnt_q;

endmodule
`default_nettype wire

/* sv/quantized_depthwise_conv_mac.sv */
// Depthwise int8 convolution multiply-accumulate, eight channel lanes.
//
// in_i   : one request per kernel tap - eight input bytes, eight filter bytes,
//          the active lane count and a last-tap flag.
// out_o  : one request per channel group, issued for the tap marked last:
//          eight 32-bit wrapping sums (lanes at or above the count read zero)
//          and the clamped lane count.
// cfg_*  : write enable, register index, data. Index 0 input zero point,
//          1 filter zero point, 2 filter signedness. Write only while idle.
//
// Throughput is one tap per cycle while in_i.ready stays high: each lane holds
// one 9x9 multiplier feeding a product register, then one 32-bit add into its
// accumulator. The last tap's products wait in the product register until the
// output register is free, and its result is then loaded into that register.
// Reset clears all accumulators, empties the pipe, sets both zero points to
// 0 and selects signed filters.
// When the receiver stalls, the result is held in the output register and
// ordinary taps keep flowing; a further last tap waits in the product stage,
// and in_i.ready drops only while that tap is blocked.
`default_nettype none
module quantized_depthwise_conv_mac import qdwc_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  qdwc_in_if.sink                    in_i,
  qdwc_out_if.source                 out_o
);

  // configuration registers
  logic [BYTE_W-1:0] izp_q, fzp_q;
  logic              fsgn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      izp_q  <= '0;
      fzp_q  <= '0;
      fsgn_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INPUT_ZP:  izp_q  <= cfg_wdata_i[BYTE_W-1:0];
        CFG_FILTER_ZP: fzp_q  <= cfg_wdata_i[BYTE_W-1:0];
        CFG_FILTER_SG: fsgn_q <= cfg_wdata_i[0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // clamp the lane count to 1..LANE_LIMIT
  cnt_t cnt_d;
  always_comb begin
    cnt_d = in_i.active_lanes;
    if (cnt_d == '0) begin
      cnt_d = cnt_t'(1);
    end else if (cnt_d > cnt_t'(LANE_LIMIT)) begin
      cnt_d = cnt_t'(LANE_LIMIT);
    end
  end

  // product stage occupancy
  logic       v1_q, last1_q;
  cnt_t       cnt1_q;
  logic       out_free, retire, load;
  lane_ctrl_t ctrl;

  // a last tap may only leave once the output register can take its result
  assign retire      = v1_q && (!last1_q || out_free);
  assign in_i.ready  = !v1_q || retire;
  assign load        = in_i.valid && in_i.ready;

  assign ctrl.load   = load;
  assign ctrl.retire = retire;
  assign ctrl.clear  = last1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (in_i.ready) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      last1_q <= in_i.last_tap;
      cnt1_q  <= cnt_d;
    end
  end

  // lanes
  acc_t sums [OUT_LANES];

  for (genvar g = 0; g < OUT_LANES; g++) begin : g_lane
    logic en;
    assign en = (g < LANE_LIMIT) && (cnt_t'(g) < cnt_d);

    qdwc_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .en_i        (en),
      .in_byte_i   (in_i.input_bytes[g*BYTE_W +: BYTE_W]),
      .filt_byte_i (in_i.filter_bytes[g*BYTE_W +: BYTE_W]),
      .izp_i       (izp_q),
      .fzp_i       (fzp_q),
      .fsgn_i      (fsgn_q),
      .sum_o       (sums[g])
    );
  end

  // result register
  qdwc_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (retire && last1_q),
    .sums_i (sums),
    .cnt_i  (cnt1_q),
    .free_o (out_free),
    .out_o  (out_o)
  );

endmodule
`default_nettype wire

/* sv/qdwc_checker.sv */
`default_nettype none
module qdwc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        in_last_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] out_sum0_i,
  input wire logic [3:0]  out_cnt_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_sum0_i) && $stable(out_cnt_i))
    else $error("stalled result changed");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_cnt_i != 4'd0 && out_cnt_i <= 4'd8)
    else $error("lane count out of range");

  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && in_last_i, 2))
    else $error("result without a last tap two cycles before");

endmodule

bind quantized_depthwise_conv_mac qdwc_checker u_qdwc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last_tap),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_sum0_i  (out_o.sum_lane0),
  .out_cnt_i   (out_o.valid_lanes)
);
`default_nettype wire
